### sv/cisc_pkg.sv
// Shared types and constants of the interpolated system clock.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package cisc_pkg;

  localparam int SHIFT_W = 5;
  localparam int REG_W   = 32;
  localparam int TIME_W  = 63;
  localparam int COUNT_W = 64;
  localparam int DELTA_W = 31;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [1:0] REG_COUNTER_SHIFT  = 2'd0;
  localparam logic [1:0] REG_SCALE_FRACTION = 2'd1;
  localparam logic [1:0] REG_SCALE_INTEGER  = 2'd2;
  localparam logic [1:0] REG_TICK_LENGTH    = 2'd3;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Reset values of the registers
  localparam logic [SHIFT_W-1:0] RST_COUNTER_SHIFT  = '0;
  localparam logic [REG_W-1:0]   RST_SCALE_FRACTION = '0;
  localparam logic [REG_W-1:0]   RST_SCALE_INTEGER  = 32'd1;
  localparam logic [REG_W-1:0]   RST_TICK_LENGTH    = 32'd10000000;

  typedef struct packed {
    logic [SHIFT_W-1:0] counter_shift;
    logic [REG_W-1:0]   scale_fraction;
    logic [REG_W-1:0]   scale_integer;
    logic [REG_W-1:0]   tick_length_ns;
  } cisc_cfg_t;

endpackage

### sv/cisc_scale.sv
// Scale stage: shifted counter sample, clamped distance and the two products.
// Holds the latched tick sample. Depends on cisc_pkg.
`timescale 1ns / 1ps

module cisc_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic                             kind_in,
  input  logic [cisc_pkg::COUNT_W-1:0]     count_in,
  input  cisc_pkg::cisc_cfg_t              cfg,
  output logic                             kind_out,
  output logic [cisc_pkg::DELTA_W-1:0]     frac_hi,
  output logic [2*cisc_pkg::DELTA_W:0]     int_prod
);
  import cisc_pkg::*;

  logic [REG_W-1:0]       latched_sample;
  logic [REG_W-1:0]       shifted;
  logic [REG_W-1:0]       diff;
  logic [DELTA_W-1:0]     delta;
  logic [DELTA_W+REG_W-1:0] frac_prod;
  logic [DELTA_W+REG_W-1:0] int_prod_c;

  logic [COUNT_W-1:0] count_sh;

  always_comb begin
    count_sh   = count_in >> cfg.counter_shift;
    shifted    = count_sh[REG_W-1:0];
    diff       = shifted - latched_sample;
    // counter behind the sample counts as no elapsed cycles
    delta      = diff[REG_W-1] ? '0 : diff[DELTA_W-1:0];
    frac_prod  = {{REG_W{1'b0}}, delta} * {{DELTA_W{1'b0}}, cfg.scale_fraction};
    int_prod_c = {{REG_W{1'b0}}, delta} * {{DELTA_W{1'b0}}, cfg.scale_integer};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_sample <= '0;
    end else if (load && (kind_in == KIND_TICK)) begin
      latched_sample <= shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_out <= kind_in;
      frac_hi  <= frac_prod[DELTA_W+REG_W-1:REG_W];
      int_prod <= int_prod_c;
    end
  end

endmodule

### sv/cisc_time.sv
// Time stage: base time update on ticks, saturating read and monotonic clamp.
// Owns the output register. Depends on cisc_pkg.
`timescale 1ns / 1ps

module cisc_time (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         kind_in,
  input  logic [cisc_pkg::COUNT_W-1:0] sum_in,
  input  cisc_pkg::cisc_cfg_t          cfg,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [cisc_pkg::TIME_W-1:0]  out_time
);
  import cisc_pkg::*;

  logic [TIME_W-1:0]  base_time;
  logic [TIME_W-1:0]  last_returned;
  logic [TIME_W:0]    tick_sum;
  logic [TIME_W-1:0]  base_next;
  logic [COUNT_W:0]   read_sum;
  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  last_returned_next;

  always_comb begin
    tick_sum  = {1'b0, base_time} + {{(TIME_W+1-REG_W){1'b0}}, cfg.tick_length_ns};
    base_next = tick_sum[TIME_W] ? TIME_MAX : tick_sum[TIME_W-1:0];
    read_sum  = {{(COUNT_W+1-TIME_W){1'b0}}, base_time} + {1'b0, sum_in};
    now       = (read_sum[COUNT_W:TIME_W] != '0) ? TIME_MAX : read_sum[TIME_W-1:0];
    last_returned_next = (now < last_returned) ? last_returned : now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time     <= '0;
      last_returned <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load && (kind_in == KIND_TICK)) begin
        base_time <= base_next;
      end
      if (load && (kind_in == KIND_READ)) begin
        last_returned <= last_returned_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (kind_in == KIND_READ)) begin
      out_time <= last_returned_next;
    end
  end

endmodule

### sv/cycle_interpolated_system_clock_core.sv
// Top level of the interpolated nanosecond system clock.
// Depends on cisc_pkg, cisc_scale and cisc_time.
`timescale 1ns / 1ps

// The block keeps a monotonic nanosecond system time from periodic tick items
// and read items that carry the free-running 64-bit cycle counter. A tick
// (tuser = 0) latches 32 counter bits, chosen by counter_shift, and advances
// the base time by tick_length_ns, saturating at 2^63-1; it gives no result.
// A read (tuser = 1) scales the cycles since the last tick by
// scale_integer.scale_fraction, adds the base time and gives one result item,
// never smaller than the one before. One item is taken every clock cycle while
// s_tready is high; a read passes from the input register through the product
// and sum registers to the output register. The stages collapse bubbles, so
// items keep flowing into empty stages while a result waits in the output
// register; input stalls only once every stage is full. Registers are written
// via cfg_wen/cfg_index/cfg_data; the user must do so only while the block is
// idle; the block does not enforce it. Resets to shift 0, scale 1.0, tick 10 ms.

module cycle_interpolated_system_clock_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] cycle_count
  input  logic        s_tuser,   // [0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [62:0] system_time_ns, [63] zero fill
  // configuration
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cisc_pkg::*;

  cisc_cfg_t cfg;

  // stage valids and handshakes
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic ready2, ready3;
  logic accept;

  // input register
  logic               kind1;
  logic [COUNT_W-1:0] count1;

  // product register
  logic                 kind2;
  logic [DELTA_W-1:0]   frac_hi2;
  logic [2*DELTA_W:0]   int_prod2;

  // sum register
  logic               kind3;
  logic [COUNT_W-1:0] sum3;

  logic              out_valid;
  logic [TIME_W-1:0] out_time;

  // Ticks never need the output register, so only a read waits on it.
  assign en3    = v3 && ((kind3 == KIND_TICK) || !out_valid || m_tready);
  assign ready3 = !v3 || en3;
  assign en2    = v2 && ready3;
  assign ready2 = !v2 || ready3;
  assign en1    = v1 && ready2;
  assign s_tready = !v1 || ready2;
  assign accept = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counter_shift  <= RST_COUNTER_SHIFT;
      cfg.scale_fraction <= RST_SCALE_FRACTION;
      cfg.scale_integer  <= RST_SCALE_INTEGER;
      cfg.tick_length_ns <= RST_TICK_LENGTH;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_COUNTER_SHIFT:  cfg.counter_shift  <= cfg_data[SHIFT_W-1:0];
        REG_SCALE_FRACTION: cfg.scale_fraction <= cfg_data;
        REG_SCALE_INTEGER:  cfg.scale_integer  <= cfg_data;
        REG_TICK_LENGTH:    cfg.tick_length_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept)   v1 <= 1'b1;
      else if (en1) v1 <= 1'b0;
      if (en1)      v2 <= 1'b1;
      else if (en2) v2 <= 1'b0;
      if (en2)      v3 <= 1'b1;
      else if (en3) v3 <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      kind1  <= s_tuser;
      count1 <= s_tdata;
    end
  end

  // Shift, distance and the two products; latched sample updates on ticks
  cisc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .load     (en1),
    .kind_in  (kind1),
    .count_in (count1),
    .cfg      (cfg),
    .kind_out (kind2),
    .frac_hi  (frac_hi2),
    .int_prod (int_prod2)
  );

  // Scaled distance: fraction product already shifted down by 32
  always_ff @(posedge clk) begin
    if (en2) begin
      kind3 <= kind2;
      sum3  <= {{(COUNT_W-DELTA_W){1'b0}}, frac_hi2}
             + {{(COUNT_W-2*DELTA_W-1){1'b0}}, int_prod2};
    end
  end

  // Base time, saturation, monotonic clamp and output register
  cisc_time u_time (
    .clk       (clk),
    .rst       (rst),
    .load      (en3),
    .kind_in   (kind3),
    .sum_in    (sum3),
    .cfg       (cfg),
    .out_ready (m_tready),
    .out_valid (out_valid),
    .out_time  (out_time)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_time};

endmodule
